/* design/rect_pixel_unpack_blit_assert.svh */
// assertion macros for the rectangle pixel unpacker
`ifndef RECT_PIXEL_UNPACK_BLIT_ASSERT_SVH
`define RECT_PIXEL_UNPACK_BLIT_ASSERT_SVH

// same-cycle implication, checked on clk with rst_n low as disable
`define RPUB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpub assertion failed");

// next-cycle implication
`define RPUB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpub assertion failed");

`endif

/* design/rpub_pkg.sv */
package rpub_pkg;

    typedef enum logic [1:0] {
        MODE_DROP = 2'd0,
        MODE_16   = 2'd1,
        MODE_24   = 2'd2,
        MODE_32   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_PIXEL      = 2'd0,
        ST_COMPRESSED = 2'd1,
        ST_BAD_DEPTH  = 2'd2
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       is_last;
    } res_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_t;

    localparam logic [3:0] HDR_IDLE       = 4'd0;
    localparam logic [3:0] HDR_FIRST      = 4'd1;
    localparam logic [3:0] HDR_LAST_FIELD = 4'd8;
    localparam logic [3:0] HDR_FORMAT     = 4'd9;
    localparam logic [3:0] HDR_PIXELS     = 4'd10;

    localparam logic [7:0] DEPTH_MASK = 8'hFE;
    localparam logic [7:0] DEPTH_16   = 8'd16;
    localparam logic [7:0] DEPTH_24   = 8'd24;
    localparam logic [7:0] DEPTH_32   = 8'd32;
    localparam int         COMPRESSED_BIT = 0;

    localparam logic [7:0] RB_SCALE     = 8'(255 / 31);
    localparam logic [7:0] G_SCALE      = 8'(255 / 63);
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [15:0] FB_WIDTH_RESET = 16'd1024;

    // build the output color from the collected bytes and the closing byte
    function automatic color_t unpack_pixel(mode_t mode, logic [23:0] accum,
                                            logic [7:0] last_byte);
        color_t      c;
        logic [15:0] v;
        v = {last_byte, accum[7:0]};
        c.alpha = ALPHA_OPAQUE;
        case (mode)
            MODE_16:
            begin
                c.red   = 8'({3'b000, v[4:0]} * RB_SCALE);
                c.green = 8'({2'b00, v[10:5]} * G_SCALE);
                c.blue  = 8'({3'b000, v[15:11]} * RB_SCALE);
            end
            MODE_24:
            begin
                c.red   = accum[7:0];
                c.green = accum[15:8];
                c.blue  = last_byte;
            end
            default:
            begin
                c.red   = accum[7:0];
                c.green = accum[15:8];
                c.blue  = accum[23:16];
                c.alpha = last_byte;
            end
        endcase
        return c;
    endfunction

endpackage

/* design/rect_pixel_unpack_blit.sv */
// channel  | handshake                    | payload
// ---------+------------------------------+-------------------------------------------
// input    | in_valid / in_stall          | data_byte, message_start
// output   | out_valid / out_stall        | status, pixel_address, red, green, blue,
//          |                              | alpha, is_last
// config   | cfg_wr_en                    | cfg_wr_data (fb_width)
//
// one byte per cycle sustained while out_stall is low; a byte's result is registered
// an input register and a result register each hold one beat
// the pixel address comes from one 17x16 multiply and an add in the result stage
// reset clears all control state and sets fb_width to 1024
// output stall holds the result and backs up into in_stall once the input register is full

`include "rect_pixel_unpack_blit_assert.svh"

module rect_pixel_unpack_blit #(
    parameter int ADDR_BITS = 26
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 message_start,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [ADDR_BITS-1:0] pixel_address,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue,
    output logic [7:0]           alpha,
    output logic                 is_last
);

    logic [15:0]          fb_width_reg;
    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_data_reg;
    logic                 s1_start_reg;
    logic                 accept;
    logic                 room;
    logic                 process;
    logic                 has_result;
    rpub_pkg::res_t       core_res;
    logic [ADDR_BITS-1:0] core_addr;
    rpub_pkg::res_t       out_res;

    assign process  = s1_valid_reg && room;
    assign in_stall = s1_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (process)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fb_width_reg <= rpub_pkg::FB_WIDTH_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_wr_en)
            begin
                fb_width_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg  <= data_byte;
            s1_start_reg <= message_start;
        end
    end

    rpub_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .process       (process),
        .data_byte     (s1_data_reg),
        .message_start (s1_start_reg),
        .fb_width      (fb_width_reg),
        .has_result    (has_result),
        .result        (core_res),
        .result_addr   (core_addr)
    );

    rpub_out_reg #(
        .ADDR_BITS (ADDR_BITS)
    ) u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (has_result),
        .load_res  (core_res),
        .load_addr (core_addr),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .room      (room),
        .res       (out_res),
        .res_addr  (pixel_address)
    );

    assign status  = out_res.status;
    assign red     = out_res.red;
    assign green   = out_res.green;
    assign blue    = out_res.blue;
    assign alpha   = out_res.alpha;
    assign is_last = out_res.is_last;

    `RPUB_ASSERT_NOW(a_err_is_last, out_valid && status != rpub_pkg::ST_PIXEL, is_last)
    `RPUB_ASSERT_NOW(a_err_no_addr, out_valid && status != rpub_pkg::ST_PIXEL,
                     pixel_address == '0)
    `RPUB_ASSERT_NEXT(a_s1_held, s1_valid_reg && !room, s1_valid_reg)
    `RPUB_ASSERT_NEXT(a_result_shown, has_result, out_valid)

endmodule

/* design/rpub_core.sv */
module rpub_core #(
    parameter int ADDR_BITS = 26
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  process,
    input  logic [7:0]            data_byte,
    input  logic                  message_start,
    input  logic [15:0]           fb_width,
    output logic                  has_result,
    output rpub_pkg::res_t        result,
    output logic [ADDR_BITS-1:0]  result_addr
);

    localparam int WORD_BITS = ADDR_BITS - 2;

    logic [3:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [15:0]     rect_x_reg, rect_x_next;
    logic [15:0]     rect_y_reg, rect_y_next;
    logic [15:0]     rect_w_reg, rect_w_next;
    logic [15:0]     rect_h_reg, rect_h_next;
    rpub_pkg::mode_t mode_reg, mode_next;
    logic [1:0]      phase_reg, phase_next;
    logic [23:0]     accum_reg, accum_next;
    logic [15:0]     col_reg, col_next;
    logic [15:0]     row_reg, row_next;

    logic [16:0]     y_sum;
    logic [16:0]     x_sum;
    logic [32:0]     row_prod;
    logic [32:0]     word_sum;
    logic [15:0]     col_inc;
    logic [15:0]     row_inc;
    logic [7:0]      depth;
    logic            pixel_out;
    rpub_pkg::color_t color;

    // framebuffer word address of the current pixel
    assign y_sum    = {1'b0, rect_y_reg} + {1'b0, row_reg};
    assign x_sum    = {1'b0, rect_x_reg} + {1'b0, col_reg};
    assign row_prod = {16'b0, y_sum} * {17'b0, fb_width};
    assign word_sum = row_prod + {16'b0, x_sum};

    assign col_inc = col_reg + 16'd1;
    assign row_inc = row_reg + 16'd1;
    assign depth   = data_byte & rpub_pkg::DEPTH_MASK;
    assign color   = rpub_pkg::unpack_pixel(mode_reg, accum_reg, data_byte);

    assign result_addr = pixel_out ? {word_sum[WORD_BITS-1:0], 2'b00} : '0;

    always_comb
    begin
        hdr_cnt_next = hdr_cnt_reg;
        rect_x_next  = rect_x_reg;
        rect_y_next  = rect_y_reg;
        rect_w_next  = rect_w_reg;
        rect_h_next  = rect_h_reg;
        mode_next    = mode_reg;
        phase_next   = phase_reg;
        accum_next   = accum_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        has_result   = 1'b0;
        pixel_out    = 1'b0;
        result       = '0;

        if (process)
        begin
            if (message_start)
            begin
                hdr_cnt_next = rpub_pkg::HDR_FIRST;
                mode_next    = rpub_pkg::MODE_DROP;
                phase_next   = 2'd0;
                accum_next   = '0;
            end
            else if (hdr_cnt_reg >= rpub_pkg::HDR_FIRST &&
                     hdr_cnt_reg <= rpub_pkg::HDR_LAST_FIELD)
            begin
                // odd count carries the low byte, even count the high byte
                if (hdr_cnt_reg == 4'd1)
                begin
                    rect_x_next = {8'h00, data_byte};
                end
                if (hdr_cnt_reg == 4'd2)
                begin
                    rect_x_next = {data_byte, rect_x_reg[7:0]};
                end
                if (hdr_cnt_reg == 4'd3)
                begin
                    rect_y_next = {8'h00, data_byte};
                end
                if (hdr_cnt_reg == 4'd4)
                begin
                    rect_y_next = {data_byte, rect_y_reg[7:0]};
                end
                if (hdr_cnt_reg == 4'd5)
                begin
                    rect_w_next = {8'h00, data_byte};
                end
                if (hdr_cnt_reg == 4'd6)
                begin
                    rect_w_next = {data_byte, rect_w_reg[7:0]};
                end
                if (hdr_cnt_reg == 4'd7)
                begin
                    rect_h_next = {8'h00, data_byte};
                end
                if (hdr_cnt_reg == 4'd8)
                begin
                    rect_h_next = {data_byte, rect_h_reg[7:0]};
                end
                hdr_cnt_next = hdr_cnt_reg + 4'd1;
            end
            else if (hdr_cnt_reg == rpub_pkg::HDR_FORMAT)
            begin
                hdr_cnt_next = rpub_pkg::HDR_PIXELS;
                col_next     = '0;
                row_next     = '0;
                phase_next   = 2'd0;
                accum_next   = '0;
                mode_next    = rpub_pkg::MODE_DROP;
                if (data_byte[rpub_pkg::COMPRESSED_BIT])
                begin
                    has_result     = 1'b1;
                    result.status  = rpub_pkg::ST_COMPRESSED;
                    result.is_last = 1'b1;
                end
                else if (depth == rpub_pkg::DEPTH_16 || depth == rpub_pkg::DEPTH_24 ||
                         depth == rpub_pkg::DEPTH_32)
                begin
                    if (rect_w_reg != 16'd0 && rect_h_reg != 16'd0)
                    begin
                        if (depth == rpub_pkg::DEPTH_16)
                        begin
                            mode_next = rpub_pkg::MODE_16;
                        end
                        else if (depth == rpub_pkg::DEPTH_24)
                        begin
                            mode_next = rpub_pkg::MODE_24;
                        end
                        else
                        begin
                            mode_next = rpub_pkg::MODE_32;
                        end
                    end
                end
                else
                begin
                    has_result     = 1'b1;
                    result.status  = rpub_pkg::ST_BAD_DEPTH;
                    result.is_last = 1'b1;
                end
            end
            else if (hdr_cnt_reg == rpub_pkg::HDR_PIXELS &&
                     mode_reg != rpub_pkg::MODE_DROP)
            begin
                if (phase_reg < 2'(mode_reg))
                begin
                    case (phase_reg)
                        2'd0:    accum_next[7:0]   = data_byte;
                        2'd1:    accum_next[15:8]  = data_byte;
                        default: accum_next[23:16] = data_byte;
                    endcase
                    phase_next = phase_reg + 2'd1;
                end
                else
                begin
                    has_result    = 1'b1;
                    pixel_out     = 1'b1;
                    result.status = rpub_pkg::ST_PIXEL;
                    result.red    = color.red;
                    result.green  = color.green;
                    result.blue   = color.blue;
                    result.alpha  = color.alpha;
                    phase_next    = 2'd0;
                    accum_next    = '0;
                    col_next      = col_inc;
                    if (col_inc >= rect_w_reg)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                        if (row_inc >= rect_h_reg)
                        begin
                            result.is_last = 1'b1;
                            mode_next      = rpub_pkg::MODE_DROP;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg <= rpub_pkg::HDR_IDLE;
            rect_x_reg  <= '0;
            rect_y_reg  <= '0;
            rect_w_reg  <= '0;
            rect_h_reg  <= '0;
            mode_reg    <= rpub_pkg::MODE_DROP;
            phase_reg   <= '0;
            accum_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            hdr_cnt_reg <= hdr_cnt_next;
            rect_x_reg  <= rect_x_next;
            rect_y_reg  <= rect_y_next;
            rect_w_reg  <= rect_w_next;
            rect_h_reg  <= rect_h_next;
            mode_reg    <= mode_next;
            phase_reg   <= phase_next;
            accum_reg   <= accum_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

endmodule

/* design/rpub_out_reg.sv */
module rpub_out_reg #(
    parameter int ADDR_BITS = 26
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  rpub_pkg::res_t        load_res,
    input  logic [ADDR_BITS-1:0]  load_addr,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic                  room,
    output rpub_pkg::res_t        res,
    output logic [ADDR_BITS-1:0]  res_addr
);

    logic                 valid_reg, valid_next;
    rpub_pkg::res_t       res_reg;
    logic [ADDR_BITS-1:0] addr_reg;

    // a new beat may enter when the held one is empty or leaves this cycle
    assign room = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= load_res;
            addr_reg <= load_addr;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;
    assign res_addr  = addr_reg;

endmodule

/* sim/testbench.sv */
module testbench;

    localparam int ADDR_BITS   = 26;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        rpub_pkg::status_t      status;
        logic [ADDR_BITS-1:0]   addr;
        rpub_pkg::color_t       color;
        logic                   last;
    } fb_write_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [15:0]          cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = '0;
    logic                 message_start = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] pixel_address;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [7:0]           alpha;
    logic                 is_last;

    // tracked copy of the block state
    logic [3:0]      hdr_pos = rpub_pkg::HDR_IDLE;
    logic [15:0]     win_x = '0;
    logic [15:0]     win_y = '0;
    logic [15:0]     win_w = '0;
    logic [15:0]     win_h = '0;
    rpub_pkg::mode_t px_mode = rpub_pkg::MODE_DROP;
    logic [1:0]      px_phase = '0;
    logic [23:0]     px_bytes = '0;
    logic [15:0]     col_pos = '0;
    logic [15:0]     row_pos = '0;
    logic [15:0]     stride = rpub_pkg::FB_WIDTH_RESET;

    fb_write_t queued_writes[$];
    int        mismatches = 0;
    int        beats_sent = 0;
    int        quiet_cycles = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    int        hold_left = 0;
    logic      hold_req = 1'b0;
    logic      hold_seen = 1'b0;

    rect_pixel_unpack_blit #(
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .message_start(message_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .pixel_address(pixel_address),
        .red(red),
        .green(green),
        .blue(blue),
        .alpha(alpha),
        .is_last(is_last)
    );

    always #10 clk = ~clk;

    task automatic unpack_byte(input logic [7:0] b, input logic s);
        fb_write_t   w;
        logic [63:0] lin;
        logic [7:0]  depth;
        logic [15:0] pix16;
        w = '0;
        if (s)
        begin
            hdr_pos  = rpub_pkg::HDR_FIRST;
            px_mode  = rpub_pkg::MODE_DROP;
            px_phase = '0;
            px_bytes = '0;
        end
        else if (hdr_pos >= rpub_pkg::HDR_FIRST && hdr_pos <= rpub_pkg::HDR_LAST_FIELD)
        begin
            // odd positions carry the low byte
            case ((hdr_pos - rpub_pkg::HDR_FIRST) >> 1)
                4'd0: win_x = hdr_pos[0] ? {8'h00, b} : {b, win_x[7:0]};
                4'd1: win_y = hdr_pos[0] ? {8'h00, b} : {b, win_y[7:0]};
                4'd2: win_w = hdr_pos[0] ? {8'h00, b} : {b, win_w[7:0]};
                default: win_h = hdr_pos[0] ? {8'h00, b} : {b, win_h[7:0]};
            endcase
            hdr_pos = hdr_pos + 4'd1;
        end
        else if (hdr_pos == rpub_pkg::HDR_FORMAT)
        begin
            hdr_pos  = rpub_pkg::HDR_PIXELS;
            col_pos  = '0;
            row_pos  = '0;
            px_phase = '0;
            px_bytes = '0;
            px_mode  = rpub_pkg::MODE_DROP;
            depth    = b & rpub_pkg::DEPTH_MASK;
            w.last   = 1'b1;
            if (b[rpub_pkg::COMPRESSED_BIT])
            begin
                w.status = rpub_pkg::ST_COMPRESSED;
                queued_writes.push_back(w);
            end
            else if (depth == rpub_pkg::DEPTH_16)
                px_mode = rpub_pkg::MODE_16;
            else if (depth == rpub_pkg::DEPTH_24)
                px_mode = rpub_pkg::MODE_24;
            else if (depth == rpub_pkg::DEPTH_32)
                px_mode = rpub_pkg::MODE_32;
            else
            begin
                w.status = rpub_pkg::ST_BAD_DEPTH;
                queued_writes.push_back(w);
            end
            if (win_w == 0 || win_h == 0)
                px_mode = rpub_pkg::MODE_DROP;
        end
        else if (hdr_pos == rpub_pkg::HDR_PIXELS && px_mode != rpub_pkg::MODE_DROP)
        begin
            // bytes per pixel is mode + 1
            if (px_phase < px_mode)
            begin
                px_bytes = px_bytes | (24'(b) << (8 * px_phase));
                px_phase = px_phase + 2'd1;
            end
            else
            begin
                w.status      = rpub_pkg::ST_PIXEL;
                w.color.alpha = rpub_pkg::ALPHA_OPAQUE;
                case (px_mode)
                    rpub_pkg::MODE_16:
                    begin
                        pix16         = {b, px_bytes[7:0]};
                        w.color.red   = {pix16[4:0], 3'b000};
                        w.color.green = {pix16[10:5], 2'b00};
                        w.color.blue  = {pix16[15:11], 3'b000};
                    end
                    rpub_pkg::MODE_24:
                    begin
                        w.color.red   = px_bytes[7:0];
                        w.color.green = px_bytes[15:8];
                        w.color.blue  = b;
                    end
                    default:
                    begin
                        w.color.red   = px_bytes[7:0];
                        w.color.green = px_bytes[15:8];
                        w.color.blue  = px_bytes[23:16];
                        w.color.alpha = b;
                    end
                endcase
                px_phase = '0;
                px_bytes = '0;
                lin = (64'(win_y) + 64'(row_pos)) * 64'(stride) + 64'(win_x) + 64'(col_pos);
                w.addr = ADDR_BITS'(lin << 2);
                col_pos = col_pos + 16'd1;
                if (col_pos >= win_w)
                begin
                    col_pos = '0;
                    row_pos = row_pos + 16'd1;
                    if (row_pos >= win_h)
                    begin
                        w.last  = 1'b1;
                        px_mode = rpub_pkg::MODE_DROP;
                    end
                end
                queued_writes.push_back(w);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_results
        fb_write_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (queued_writes.size() == 0)
                report_mismatch("result with none expected", 32'(pixel_address), '0);
            else
            begin
                want = queued_writes.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(status), 32'(want.status));
                if (pixel_address !== want.addr)
                    report_mismatch("pixel_address", 32'(pixel_address), 32'(want.addr));
                if (red !== want.color.red)
                    report_mismatch("red", 32'(red), 32'(want.color.red));
                if (green !== want.color.green)
                    report_mismatch("green", 32'(green), 32'(want.color.green));
                if (blue !== want.color.blue)
                    report_mismatch("blue", 32'(blue), 32'(want.color.blue));
                if (alpha !== want.color.alpha)
                    report_mismatch("alpha", 32'(alpha), 32'(want.color.alpha));
                if (is_last !== want.last)
                    report_mismatch("is_last", 32'(is_last), 32'(want.last));
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_beat(input logic [7:0] b, input logic s);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        message_start <= s;
        do
            @(posedge clk);
        while (in_stall);
        unpack_byte(b, s);
        beats_sent++;
    endtask

    task automatic send_message(input logic [79:0] hdr, input int hdr_len,
                                input logic [7:0] body[$]);
        for (int i = 0; i < hdr_len; i++)
            send_beat(hdr[8*i +: 8], i == 0);
        foreach (body[i])
            send_beat(body[i], 1'b0);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (queued_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_fb_width(input logic [15:0] w);
        drain_pipeline();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        stride = w;
    endtask

    function automatic logic [79:0] header_bytes(input logic [7:0] cmd, input logic [15:0] x,
                                                 input logic [15:0] y, input logic [15:0] w,
                                                 input logic [15:0] h, input logic [7:0] fmt);
        return {fmt, h, w, y, x, cmd};
    endfunction

    function automatic logic [15:0] corner_value();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] data_value();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] raw_depth();
        case ($urandom_range(0, 2))
            0: return rpub_pkg::DEPTH_16;
            1: return rpub_pkg::DEPTH_24;
            default: return rpub_pkg::DEPTH_32;
        endcase
    endfunction

    task automatic send_random_message();
        logic [7:0]  body[$];
        logic [7:0]  fmt;
        logic [15:0] x, y, w, h;
        int          kind, bpp, n, hdr_len, cut;
        kind    = $urandom_range(0, 99);
        x       = corner_value();
        y       = corner_value();
        w       = 16'($urandom_range(1, 4));
        h       = 16'($urandom_range(1, 3));
        hdr_len = 10;
        bpp     = 0;
        cut     = -1;
        if (kind < 24)
        begin
            fmt = rpub_pkg::DEPTH_16;
            bpp = 2;
        end
        else if (kind < 48)
        begin
            fmt = rpub_pkg::DEPTH_24;
            bpp = 3;
        end
        else if (kind < 72)
        begin
            fmt = rpub_pkg::DEPTH_32;
            bpp = 4;
        end
        else if (kind < 80)
            fmt = 8'($urandom) | 8'h01;
        else if (kind < 88)
        begin
            do
                fmt = 8'($urandom) & rpub_pkg::DEPTH_MASK;
            while (fmt == rpub_pkg::DEPTH_16 || fmt == rpub_pkg::DEPTH_24 ||
                   fmt == rpub_pkg::DEPTH_32);
        end
        else if (kind < 93)
        begin
            // empty rectangle
            fmt = raw_depth();
            if ($urandom_range(0, 1) == 0)
            begin
                w = 16'h0000;
                h = 16'($urandom);
            end
            else
            begin
                w = 16'($urandom);
                h = 16'h0000;
            end
        end
        else
        begin
            // big rectangle cut short by the next start
            fmt = raw_depth();
            w   = 16'($urandom);
            h   = 16'($urandom);
            cut = $urandom_range(1, 40);
        end
        if (cut >= 0)
        begin
            hdr_len = (cut < 10) ? cut : 10;
            n       = cut - hdr_len;
        end
        else
        begin
            n = (bpp != 0) ? bpp * int'(w) * int'(h) : $urandom_range(0, 4);
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, 3);
        end
        for (int i = 0; i < n; i++)
            body.push_back(data_value());
        send_message(header_bytes(data_value(), x, y, w, h, fmt), hdr_len, body);
    endtask

    task automatic send_random_beats(input int count);
        int first;
        first = beats_sent;
        while (beats_sent - first < count)
            send_random_message();
    endtask

    task automatic test_directed();
        logic [7:0] body[$];
        tx_idle_pct = 20;
        rx_idle_pct = 71;
        // stray bytes ahead of any start
        send_beat(8'hA5, 1'b0);
        send_beat(8'h5A, 1'b0);
        // 16-bit pixels at the far corner, address wraps, trailing byte dropped
        body = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF};
        send_message(header_bytes(8'h00, 16'hFFFF, 16'hFFFF, 16'd2, 16'd1,
                                  rpub_pkg::DEPTH_16), 10, body);
        // compressed data
        body = '{8'h81};
        send_message(header_bytes(8'hFF, 16'h0000, 16'h0000, 16'd1, 16'd1, 8'h01), 10, body);
    endtask

    task automatic test_fb_width_extremes();
        write_fb_width(16'd1);
        send_random_beats(70);
        write_fb_width(16'hFFFF);
        send_random_beats(70);
        write_fb_width(16'd0);
        send_random_beats(70);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_fb_width(16'($urandom_range(1, 65535)));
        send_random_beats(count);
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_fb_width(16'($urandom_range(1, 2048)));
        hold_req <= ~hold_req;
        send_random_beats(150);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fb_width_extremes();
        test_random_traffic(20, 71, 500);
        test_random_traffic(71, 20, 500);
        test_random_traffic(0, 0, 500);
        test_backpressure();
        drain_pipeline();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/rpub_pkg.sv
design/rpub_core.sv
design/rpub_out_reg.sv
design/rect_pixel_unpack_blit.sv
sim/testbench.sv
